// ===== src/bcap_pkg.sv =====
// ----------------------------------------------------------------------------
// bcap_pkg
// Shared types and constants of the buzzer chirp/alarm pattern generator.
// ----------------------------------------------------------------------------
package bcap_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int COUNT_WIDTH = 8;
	localparam int TICKS_WIDTH = 16;
	localparam int VALUE_WIDTH = 8;
	localparam int OP_WIDTH    = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CMP_WIDTH   = 33;
	localparam int OUT_DATA_W  = 16;

	typedef enum logic [OP_WIDTH-1:0] {
		OP_TICK    = 2'd0,
		OP_ERROR   = 2'd1,
		OP_BATTERY = 2'd2,
		OP_CHIRP   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHIRP_HIGH   = 3'd0,
		REG_CHIRP_LOW    = 3'd1,
		REG_BATTERY_HIGH = 3'd2,
		REG_BATTERY_LOW  = 3'd3,
		REG_ERROR_HIGH   = 3'd4,
		REG_ERROR_LOW    = 3'd5
	} reg_idx_t;

	localparam logic [TICKS_WIDTH-1:0] CHIRP_HIGH_RST   = 16'd50;
	localparam logic [TICKS_WIDTH-1:0] CHIRP_LOW_RST    = 16'd50;
	localparam logic [TICKS_WIDTH-1:0] BATTERY_HIGH_RST = 16'd200;
	localparam logic [TICKS_WIDTH-1:0] BATTERY_LOW_RST  = 16'd800;
	localparam logic [TICKS_WIDTH-1:0] ERROR_HIGH_RST   = 16'd100;
	localparam logic [TICKS_WIDTH-1:0] ERROR_LOW_RST    = 16'd100;

	// One result item, as packed into the output tdata (level in bit 0).
	typedef struct packed {
		logic [7:0] chirps_pending;
		logic       battery_flag;
		logic       error_flag;
		logic       buzzer_level;
	} result_t;

	// Configuration write, top level to core.
	typedef struct packed {
		logic                 wr;
		logic [CFG_IDX_W-1:0] idx;
		logic [TICKS_WIDTH-1:0] data;
	} cfg_wr_t;

endpackage

// ===== src/bcap_core.sv =====
// ----------------------------------------------------------------------------
// bcap_core
// Pattern state and duration registers; applies one event per step and
// presents the result that the event leaves behind.
// ----------------------------------------------------------------------------
module bcap_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bcap_pkg::cfg_wr_t                   cfg,
	input  logic                                step,
	input  logic [bcap_pkg::OP_WIDTH-1:0]       operation,
	input  logic [bcap_pkg::VALUE_WIDTH-1:0]    value,
	output bcap_pkg::result_t                   result
);

	logic [bcap_pkg::TICKS_WIDTH-1:0] chirp_high_q, chirp_low_q;
	logic [bcap_pkg::TICKS_WIDTH-1:0] battery_high_q, battery_low_q;
	logic [bcap_pkg::TICKS_WIDTH-1:0] error_high_q, error_low_q;

	logic [bcap_pkg::COUNT_WIDTH-1:0] chirps_q, chirps_d;
	logic                             phase_q, phase_d;
	logic                             error_q, error_d;
	logic                             battery_q, battery_d;
	logic [bcap_pkg::TIMER_WIDTH-1:0] elapsed_q, elapsed_d;
	logic                             drive_q, drive_d;

	logic [bcap_pkg::TIMER_WIDTH-1:0] elapsed_inc;
	logic [bcap_pkg::TICKS_WIDTH-1:0] limit;
	logic                             active;
	logic                             expired;
	logic                             burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chirp_high_q   <= bcap_pkg::CHIRP_HIGH_RST;
			chirp_low_q    <= bcap_pkg::CHIRP_LOW_RST;
			battery_high_q <= bcap_pkg::BATTERY_HIGH_RST;
			battery_low_q  <= bcap_pkg::BATTERY_LOW_RST;
			error_high_q   <= bcap_pkg::ERROR_HIGH_RST;
			error_low_q    <= bcap_pkg::ERROR_LOW_RST;
		end else if (cfg.wr) begin
			case (bcap_pkg::reg_idx_t'(cfg.idx))
				bcap_pkg::REG_CHIRP_HIGH:   chirp_high_q   <= cfg.data;
				bcap_pkg::REG_CHIRP_LOW:    chirp_low_q    <= cfg.data;
				bcap_pkg::REG_BATTERY_HIGH: battery_high_q <= cfg.data;
				bcap_pkg::REG_BATTERY_LOW:  battery_low_q  <= cfg.data;
				bcap_pkg::REG_ERROR_HIGH:   error_high_q   <= cfg.data;
				bcap_pkg::REG_ERROR_LOW:    error_low_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign burst  = (chirps_q != '0);
	assign active = burst || error_q || battery_q;
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;

	always_comb begin
		if (phase_q) begin
			limit = burst ? chirp_high_q : (battery_q ? battery_high_q : error_high_q);
		end else begin
			limit = burst ? chirp_low_q : (battery_q ? battery_low_q : error_low_q);
		end
	end

	assign expired = bcap_pkg::CMP_WIDTH'(elapsed_inc) > bcap_pkg::CMP_WIDTH'(limit);

	always_comb begin
		chirps_d  = chirps_q;
		phase_d   = phase_q;
		error_d   = error_q;
		battery_d = battery_q;
		elapsed_d = elapsed_q;
		drive_d   = drive_q;
		case (bcap_pkg::op_t'(operation))
			bcap_pkg::OP_TICK: begin
				elapsed_d = elapsed_inc;
				if (!active) begin
					drive_d = 1'b0;
				end else begin
					if (expired) begin
						phase_d   = !phase_q;
						elapsed_d = '0;
						if (phase_q && burst) begin
							chirps_d = chirps_q - 1'b1;
						end
					end
					drive_d = expired ? !phase_q : phase_q;
				end
			end
			bcap_pkg::OP_ERROR:   error_d   = value[0];
			bcap_pkg::OP_BATTERY: battery_d = value[0];
			bcap_pkg::OP_CHIRP: begin
				chirps_d  = bcap_pkg::COUNT_WIDTH'(value);
				phase_d   = !(error_q || battery_q);
				elapsed_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chirps_q  <= '0;
			phase_q   <= 1'b0;
			error_q   <= 1'b0;
			battery_q <= 1'b0;
			elapsed_q <= '0;
			drive_q   <= 1'b0;
		end else if (step) begin
			chirps_q  <= chirps_d;
			phase_q   <= phase_d;
			error_q   <= error_d;
			battery_q <= battery_d;
			elapsed_q <= elapsed_d;
			drive_q   <= drive_d;
		end
	end

	assign result.buzzer_level   = drive_d;
	assign result.error_flag     = error_d;
	assign result.battery_flag   = battery_d;
	assign result.chirps_pending = 8'(chirps_d);

endmodule

// ===== src/buzzer_chirp_alarm_pattern.sv =====
// ----------------------------------------------------------------------------
// buzzer_chirp_alarm_pattern
// Buzzer pattern generator: ticks, alarm enables and chirp bursts in, one
// status item with the buzzer level out per event.
// ----------------------------------------------------------------------------
// Every input transfer yields exactly one output transfer. The block takes one
// event per cycle while the output side keeps taking transfers: the event is
// applied to the pattern state in a single pass of logic and the resulting
// status is written into the output register in the same cycle. The single
// output register is the only buffer: a new event is taken whenever that
// register is empty or is being drained in the same cycle. Event kinds travel
// in s_axis_tuser (tick, set error alarm, set battery alarm, start chirp
// burst); s_axis_tdata bit 0 is the alarm enable, or the whole byte is the
// chirp count. A chirp burst beats the battery alarm, which beats the error
// alarm; a phase flips once its tick count strictly exceeds the selected
// duration. Duration registers are written through the cfg channel, which is
// always ready; write them only while no event is in flight.
// ----------------------------------------------------------------------------
module buzzer_chirp_alarm_pattern (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Event input
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [7:0] value
	input  logic [1:0]                           s_axis_tuser,  // [1:0] operation
	// Status output
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [bcap_pkg::OUT_DATA_W-1:0]      m_axis_tdata,  // [0] buzzer_level,
	                                                             // [1] error_flag,
	                                                             // [2] battery_flag,
	                                                             // [10:3] chirps_pending,
	                                                             // [15:11] zero
	// Duration register writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bcap_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bcap_pkg::TICKS_WIDTH-1:0]     cfg_data
);

	logic               in_xfer;
	bcap_pkg::cfg_wr_t  cfg_wr;
	bcap_pkg::result_t  result;
	logic               out_valid_q;
	bcap_pkg::result_t  out_data_q;

	// Writes go straight into the duration registers; never hold the channel off.
	assign cfg_ready   = 1'b1;
	assign cfg_wr.wr   = cfg_valid;
	assign cfg_wr.idx  = cfg_index;
	assign cfg_wr.data = cfg_data;

	// Take a new event when the output register is empty or drains this cycle.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	bcap_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_wr),
		.step      (in_xfer),
		.operation (s_axis_tuser),
		.value     (s_axis_tdata),
		.result    (result)
	);

	// Output register: load on every accepted event, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = bcap_pkg::OUT_DATA_W'(out_data_q);

endmodule

// ===== src/bcap_checker.sv =====
// ----------------------------------------------------------------------------
// bcap_checker
// Port-level checks of the buzzer pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
module bcap_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	input  logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,
	input  logic [1:0]                       s_axis_tuser,
	input  logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic [bcap_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

	logic in_xfer;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// An accepted event always shows up as a status item in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> m_axis_tvalid)
		else $error("accepted event produced no status item");

	// An empty output register never holds the input off.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// An error alarm enable is reflected in the status of the same event.
	a_error_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == bcap_pkg::OP_ERROR)
		|=> m_axis_tdata[1] == $past(s_axis_tdata[0]))
		else $error("error flag does not follow its set event");

	// A chirp start loads the pending count directly.
	a_chirp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_axis_tuser == bcap_pkg::OP_CHIRP)
		|=> m_axis_tdata[10:3] == $past(s_axis_tdata))
		else $error("chirp count not loaded");

	// A stalled status item holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled status item changed");

endmodule

bind buzzer_chirp_alarm_pattern bcap_checker u_bcap_checker (.*);

// ===== bench/buzzer_chirp_alarm_pattern_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buzzer_chirp_alarm_pattern_tb
// Self-checking bench for the buzzer pattern generator. A scoreboard object
// keeps its own copy of the duration registers and of the pattern state. For
// every accepted event it predicts the status transfer that must come back,
// and it compares each returned status with the oldest prediction.
// ----------------------------------------------------------------------------
module buzzer_chirp_alarm_pattern_tb;

	// Register indexes past the last duration register: writes there are dropped.
	localparam logic [bcap_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [bcap_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [bcap_pkg::TICKS_WIDTH-1:0] TICKS_MAX = '1;
	localparam int REPORT_LIMIT = 10;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [7:0]                         s_axis_tdata;   // [7:0] value
	logic [1:0]                         s_axis_tuser;   // [1:0] operation
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [bcap_pkg::OUT_DATA_W-1:0]    m_axis_tdata;   // [0] level, [1] error,
	                                                    // [2] battery,
	                                                    // [10:3] chirps pending,
	                                                    // [15:11] zero
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [bcap_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [bcap_pkg::TICKS_WIDTH-1:0]   cfg_data;

	// Idling controls for the sender and the receiver.
	bit tx_idle;
	bit rx_idle;
	int rx_hold;
	int rx_gap;

	buzzer_chirp_alarm_pattern DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Pattern predictor and store of expected status items
	// ------------------------------------------------------------------------
	class status_scoreboard;
		logic [bcap_pkg::TICKS_WIDTH-1:0] durations [6];
		logic [bcap_pkg::COUNT_WIDTH-1:0] chirps_left;
		logic [bcap_pkg::TIMER_WIDTH-1:0] elapsed;
		bit                               phase_high;
		bit                               error_on;
		bit                               battery_on;
		bit                               level;
		bcap_pkg::result_t                expected_q [$];
		int                               failures;

		function new();
			durations[bcap_pkg::REG_CHIRP_HIGH]   = bcap_pkg::CHIRP_HIGH_RST;
			durations[bcap_pkg::REG_CHIRP_LOW]    = bcap_pkg::CHIRP_LOW_RST;
			durations[bcap_pkg::REG_BATTERY_HIGH] = bcap_pkg::BATTERY_HIGH_RST;
			durations[bcap_pkg::REG_BATTERY_LOW]  = bcap_pkg::BATTERY_LOW_RST;
			durations[bcap_pkg::REG_ERROR_HIGH]   = bcap_pkg::ERROR_HIGH_RST;
			durations[bcap_pkg::REG_ERROR_LOW]    = bcap_pkg::ERROR_LOW_RST;
			chirps_left = '0;
			elapsed     = '0;
			phase_high  = 1'b0;
			error_on    = 1'b0;
			battery_on  = 1'b0;
			level       = 1'b0;
			failures    = 0;
		endfunction

		function void set_duration(logic [bcap_pkg::CFG_IDX_W-1:0] idx,
		                           logic [bcap_pkg::TICKS_WIDTH-1:0] data);
			if (idx <= bcap_pkg::REG_ERROR_LOW)
				durations[idx] = data;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advance the pattern by one tick: count, compare, flip, drive.
		function void advance_tick();
			logic [bcap_pkg::TICKS_WIDTH-1:0] limit;
			if (elapsed != TICKS_MAX)
				elapsed++;
			if (chirps_left == 0 && !error_on && !battery_on) begin
				level = 1'b0;
				return;
			end
			if (phase_high) begin
				limit = (chirps_left != 0) ? durations[bcap_pkg::REG_CHIRP_HIGH] :
				        battery_on ? durations[bcap_pkg::REG_BATTERY_HIGH] :
				        durations[bcap_pkg::REG_ERROR_HIGH];
				if (elapsed > limit) begin
					if (chirps_left != 0)
						chirps_left--;
					phase_high = 1'b0;
					elapsed    = '0;
				end
			end else begin
				limit = (chirps_left != 0) ? durations[bcap_pkg::REG_CHIRP_LOW] :
				        battery_on ? durations[bcap_pkg::REG_BATTERY_LOW] :
				        durations[bcap_pkg::REG_ERROR_LOW];
				if (elapsed > limit) begin
					phase_high = 1'b1;
					elapsed    = '0;
				end
			end
			level = phase_high;
		endfunction

		function void note_event(bcap_pkg::op_t op, logic [7:0] value);
			bcap_pkg::result_t status;
			case (op)
				bcap_pkg::OP_TICK: begin
					advance_tick();
				end
				bcap_pkg::OP_ERROR: begin
					error_on = value[0];
				end
				bcap_pkg::OP_BATTERY: begin
					battery_on = value[0];
				end
				default: begin
					chirps_left = value[bcap_pkg::COUNT_WIDTH-1:0];
					phase_high  = !(error_on || battery_on);
					elapsed     = '0;
				end
			endcase
			status.buzzer_level   = level;
			status.error_flag     = error_on;
			status.battery_flag   = battery_on;
			status.chirps_pending = chirps_left;
			expected_q.push_back(status);
		endfunction

		function void check_status(logic [bcap_pkg::OUT_DATA_W-1:0] data);
			bcap_pkg::result_t want;
			bcap_pkg::result_t got;
			got = data[$bits(bcap_pkg::result_t)-1:0];
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("status transfer with nothing expected: %h", data);
				return;
			end
			want = expected_q.pop_front();
			if (data[bcap_pkg::OUT_DATA_W-1:$bits(bcap_pkg::result_t)] !== '0 ||
			    got.buzzer_level !== want.buzzer_level ||
			    got.error_flag !== want.error_flag ||
			    got.battery_flag !== want.battery_flag ||
			    got.chirps_pending !== want.chirps_pending) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display({"status mismatch: level %b/%b error %b/%b battery %b/%b",
					          " chirps %0d/%0d pad %h (expected/actual)"},
					         want.buzzer_level, got.buzzer_level,
					         want.error_flag, got.error_flag,
					         want.battery_flag, got.battery_flag,
					         want.chirps_pending, got.chirps_pending,
					         data[bcap_pkg::OUT_DATA_W-1:$bits(bcap_pkg::result_t)]);
			end
		endfunction
	endclass

	status_scoreboard sb = new();

	// ------------------------------------------------------------------------
	// Monitor: every transfer is seen at the rising edge. Check returned status
	// first; it always belongs to an event accepted on an earlier edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_status(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_event(bcap_pkg::op_t'(s_axis_tuser), s_axis_tdata);
			if (cfg_valid && cfg_ready)
				sb.set_duration(cfg_index, cfg_data);
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: a requested hold-off wins, then random stall bursts, else ready.
	// The hold-off is counted down here so the sender keeps offering meanwhile.
	// ------------------------------------------------------------------------
	initial begin
		m_axis_tready = 1'b0;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_axis_tready = 1'b0;
				rx_hold--;
			end else if (rx_gap > 0) begin
				m_axis_tready = 1'b0;
				rx_gap--;
			end else if (rx_idle && $urandom_range(0, 9) == 0) begin
				m_axis_tready = 1'b0;
				rx_gap = $urandom_range(1, 17) - 1;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// Offer one event; return at the edge where it transfers. Valid stays high
	// into the next call unless that call opens an idle burst.
	task automatic send_event(input bcap_pkg::op_t op, input logic [7:0] value);
		int gap;
		if (tx_idle && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 17);
			@(negedge clk);
			s_axis_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = op;
		s_axis_tdata  = value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Drop valid and hold until every predicted status has come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bcap_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [bcap_pkg::TICKS_WIDTH-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// Load all durations from 0..top, poke the unused indexes, then drop valid.
	task automatic write_durations(input int unsigned top);
		write_reg(bcap_pkg::REG_CHIRP_HIGH,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(bcap_pkg::REG_CHIRP_LOW,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(bcap_pkg::REG_BATTERY_HIGH,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(bcap_pkg::REG_BATTERY_LOW,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(bcap_pkg::REG_ERROR_HIGH,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(bcap_pkg::REG_ERROR_LOW,
		          bcap_pkg::TICKS_WIDTH'($urandom_range(0, top)));
		write_reg(REG_SPARE_LO, bcap_pkg::TICKS_WIDTH'($urandom_range(0, 65535)));
		write_reg(REG_SPARE_HI, bcap_pkg::TICKS_WIDTH'($urandom_range(0, 65535)));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly ticks so patterns run through their phases; alarm edits and new
	// bursts break in now and then. Bursts are usually short, rarely huge.
	task automatic run_events(input int count);
		int pick;
		logic [7:0] value;
		for (int n = 0; n < count; n++) begin
			pick  = $urandom_range(0, 99);
			value = 8'($urandom_range(0, 255));
			if (pick < 62) begin
				send_event(bcap_pkg::OP_TICK, value);
			end else if (pick < 72) begin
				send_event(bcap_pkg::OP_ERROR, value);
			end else if (pick < 82) begin
				send_event(bcap_pkg::OP_BATTERY, value);
			end else begin
				if ($urandom_range(0, 9) != 0)
					value = 8'($urandom_range(0, 4));
				send_event(bcap_pkg::OP_CHIRP, value);
			end
			// Pause the sender now and then until everything has come back.
			if ($urandom_range(0, 149) == 0)
				drain();
		end
	endtask

	// ------------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = bcap_pkg::OP_TICK;
		cfg_valid     = 1'b0;
		cfg_index     = bcap_pkg::REG_CHIRP_HIGH;
		cfg_data      = '0;
		tx_idle       = 1'b0;
		rx_idle       = 1'b0;
		rx_hold       = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed events with reset durations: field extremes, alarm bit 0
		// alone deciding, zero-count burst, full-count burst, bursts that
		// start low because an alarm is on.
		send_event(bcap_pkg::OP_TICK, 8'hFF);
		send_event(bcap_pkg::OP_ERROR, 8'hFE);
		send_event(bcap_pkg::OP_ERROR, 8'h01);
		send_event(bcap_pkg::OP_BATTERY, 8'hFF);
		send_event(bcap_pkg::OP_BATTERY, 8'h00);
		send_event(bcap_pkg::OP_ERROR, 8'h00);
		send_event(bcap_pkg::OP_CHIRP, 8'h00);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_CHIRP, 8'hFF);
		send_event(bcap_pkg::OP_TICK, 8'h5A);
		send_event(bcap_pkg::OP_TICK, 8'hA5);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_CHIRP, 8'hAA);
		send_event(bcap_pkg::OP_ERROR, 8'h55);
		send_event(bcap_pkg::OP_CHIRP, 8'h02);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_BATTERY, 8'h03);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_CHIRP, 8'h00);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		send_event(bcap_pkg::OP_ERROR, 8'h00);
		send_event(bcap_pkg::OP_BATTERY, 8'h00);
		send_event(bcap_pkg::OP_TICK, 8'h00);
		drain();

		// Zero durations: every tick flips the phase while a pattern is active.
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_durations(0);
		run_events(200);
		drain();

		// Short durations with the receiver held off for a long stretch first,
		// so the output register fills and input transfers stall.
		write_durations(3);
		rx_hold = 60;
		run_events(200);
		drain();

		// Slightly longer phases, no idling on either side.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_durations(7);
		run_events(200);
		drain();

		// Durations from the full 16-bit range: patterns seldom leave their first phase here.
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_durations(65535);
		run_events(120);
		drain();

		write_durations(15);
		rx_hold = 40;
		run_events(200);
		drain();

		// Full-range high duration for the error alarm: any short low phase
		// ends, then the high phase holds for the rest of this stretch.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_reg(bcap_pkg::REG_ERROR_HIGH, TICKS_MAX);
		@(negedge clk);
		cfg_valid = 1'b0;
		send_event(bcap_pkg::OP_BATTERY, 8'h00);
		send_event(bcap_pkg::OP_CHIRP, 8'h00);
		send_event(bcap_pkg::OP_ERROR, 8'h01);
		repeat (24) send_event(bcap_pkg::OP_TICK, 8'($urandom_range(0, 255)));
		send_event(bcap_pkg::OP_ERROR, 8'h00);
		drain();

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		write_durations(2);
		run_events(300);
		drain();

		// Closing stretch at full rate.
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		write_durations(3);
		run_events(180);
		drain();
		repeat (10) @(posedge clk);

		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bcap_pkg.sv
src/bcap_core.sv
src/buzzer_chirp_alarm_pattern.sv
src/bcap_checker.sv
bench/buzzer_chirp_alarm_pattern_tb.sv
